// File: hdl/sva_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sva_pkg
// Shared constants, request codes and controller/datapath interface types
// for the synth voice allocator.
// ============================================================================
package sva_pkg;

    // Defaults and fixed constants
    localparam int MAX_VOICES_DEF   = 18;
    localparam int INSTRUMENT_COUNT = 175;
    localparam int PERC_CHANNEL     = 9;
    localparam int VOICE_COUNT_RST  = 18;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int CHAN_W   = 4;
    localparam int VEL_W    = 7;
    localparam int PPATCH_W = 8;
    localparam int SPATCH_W = 9;
    localparam int NOW_W    = 31;
    localparam int VCNT_W   = 5;
    localparam int VSLOT_W  = 5;
    localparam int PATCH_W  = 10;   // stored patch, all ones means none
    localparam int VCHAN_W  = 5;    // stored channel, all ones means unassigned
    localparam int VTIME_W  = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REBASE   = 2'd3;

    // Result actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_VOICE_COUNT = 1'b0;
    localparam logic REG_DUAL_ENABLE = 1'b1;

    localparam logic [PATCH_W-1:0] PATCH_NONE  = 10'h3FF;
    localparam logic [VCHAN_W-1:0] CHAN_NONE   = 5'h1F;
    localparam logic [VTIME_W-1:0] TIME_NONE   = 32'hFFFF_FFFF;
    localparam logic [NOTE_W-1:0]  PERC_LOW    = 7'd35;
    localparam logic [NOTE_W-1:0]  PERC_HIGH   = 7'd82;
    localparam logic [VEL_W-1:0]   RESET_VEL   = 7'd64;
    localparam logic [PATCH_W-1:0] INSTR_LIMIT = 10'(INSTRUMENT_COUNT);
    localparam logic [CHAN_W-1:0]  PERC_CHAN   = 4'(PERC_CHANNEL);

    typedef struct packed {
        logic load_req;      // capture request, arm primary scan
        logic init_second;   // arm secondary scan
        logic scan_step;     // evaluate one voice for selection
        logic start_voice;   // commit selected voice, issue start
        logic sweep_step;    // process one voice for off/reset/rebase
    } sva_cmd_t;

    typedef struct packed {
        logic scan_end;      // selection finishes on this step
        logic want_second;   // secondary voice follows the primary
        logic sweep_last;    // current voice is the last in range
        logic sweep_emit;    // current voice produces a stop
        logic out_free;      // output register can take a result
    } sva_status_t;

    function automatic logic perc_ok(input logic [NOTE_W-1:0] n);
        perc_ok = (n < PERC_HIGH) && (n >= PERC_LOW);
    endfunction

endpackage

// File: hdl/sva_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// sva_ctrl
// Sequencer for the voice allocator: primary and secondary selection scans,
// voice starts, and the per-voice sweep for note-off, reset and rebase.
// ============================================================================
module sva_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sva_pkg::REQ_W-1:0]     req_type,
    input  sva_pkg::sva_status_t          status,
    output logic                          in_ready,
    output sva_pkg::sva_cmd_t             cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN1  = 3'd1;
    localparam logic [2:0] S_START1 = 3'd2;
    localparam logic [2:0] S_SCAN2  = 3'd3;
    localparam logic [2:0] S_START2 = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = (req_type == sva_pkg::REQ_NOTE_ON) ? S_SCAN1 : S_SWEEP;
                end
            end
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = S_START1;
                end
            end
            S_START1:
            begin
                if (status.out_free)
                begin
                    cmd.start_voice = 1'b1;
                    if (status.want_second)
                    begin
                        cmd.init_second = 1'b1;
                        state_next      = S_SCAN2;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = S_START2;
                end
            end
            S_START2:
            begin
                if (status.out_free)
                begin
                    cmd.start_voice = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                // hold while a stop is due and the output is still full
                if (!status.sweep_emit || status.out_free)
                begin
                    cmd.sweep_step = 1'b1;
                    if (status.sweep_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/sva_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// sva_dp
// Voice allocator datapath: per-voice state, single-port scan over voices,
// selection registers for free/steal picks, and the result register.
// ============================================================================
module sva_dp
#(
    parameter int MAX_VOICES = sva_pkg::MAX_VOICES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [sva_pkg::VCNT_W-1:0]       voice_count,
    input  logic                             dual_enable,
    input  logic [sva_pkg::REQ_W-1:0]        req_type,
    input  logic [sva_pkg::NOTE_W-1:0]       note,
    input  logic [sva_pkg::CHAN_W-1:0]       channel,
    input  logic [sva_pkg::VEL_W-1:0]        velocity,
    input  logic [sva_pkg::PPATCH_W-1:0]     primary_patch,
    input  logic [sva_pkg::SPATCH_W-1:0]     secondary_patch,
    input  logic                             double_voice,
    input  logic [sva_pkg::NOW_W-1:0]        now,
    input  sva_pkg::sva_cmd_t                cmd,
    output sva_pkg::sva_status_t             status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             action,
    output logic [sva_pkg::VSLOT_W-1:0]      voice,
    output logic [sva_pkg::NOTE_W-1:0]       note_out,
    output logic [sva_pkg::VEL_W-1:0]        velocity_out,
    output logic [sva_pkg::SPATCH_W-1:0]     patch,
    output logic                             patch_load,
    output logic                             is_secondary,
    output logic                             last
);

    localparam int VW       = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW       = $clog2(MAX_VOICES + 1);
    localparam int FREE_RST = (sva_pkg::VOICE_COUNT_RST > MAX_VOICES) ?
                              MAX_VOICES : sva_pkg::VOICE_COUNT_RST;

    // per-voice state
    logic [MAX_VOICES-1:0]              act_reg, act_next;
    logic [MAX_VOICES-1:0]              vsec_reg, vsec_next;
    logic [sva_pkg::NOTE_W-1:0]         vnote_reg [MAX_VOICES];
    logic [sva_pkg::NOTE_W-1:0]         vnote_next [MAX_VOICES];
    logic [sva_pkg::VCHAN_W-1:0]        vch_reg [MAX_VOICES];
    logic [sva_pkg::VCHAN_W-1:0]        vch_next [MAX_VOICES];
    logic [sva_pkg::VTIME_W-1:0]        vtime_reg [MAX_VOICES];
    logic [sva_pkg::VTIME_W-1:0]        vtime_next [MAX_VOICES];
    logic [sva_pkg::PATCH_W-1:0]        vpatch_reg [MAX_VOICES];
    logic [sva_pkg::PATCH_W-1:0]        vpatch_next [MAX_VOICES];
    logic [CW-1:0]                      free_reg, free_next;

    // captured request
    logic [sva_pkg::REQ_W-1:0]          req_reg;
    logic [sva_pkg::NOTE_W-1:0]         note_reg;
    logic [sva_pkg::CHAN_W-1:0]         ch_reg;
    logic [sva_pkg::VEL_W-1:0]          vel_reg;
    logic [sva_pkg::PPATCH_W-1:0]       ppatch_reg;
    logic [sva_pkg::SPATCH_W-1:0]       spatch_reg;
    logic                               dbl_reg;
    logic [sva_pkg::NOW_W-1:0]          now_reg;

    // scan state
    logic [VW-1:0]                      idx_reg, idx_next;
    logic [VW-1:0]                      best_voice_reg, best_voice_next;
    logic [sva_pkg::VTIME_W-1:0]        best_time_reg, best_time_next;
    logic [sva_pkg::PATCH_W-1:0]        best_patch_reg, best_patch_next;
    logic                               same_reg, same_next;
    logic                               secf_reg, secf_next;
    logic                               scan_sec_reg, scan_sec_next;
    logic                               steal_reg, steal_next;

    // result register
    logic                               ovalid_reg, ovalid_next;
    logic                               oact_reg, oact_next;
    logic [sva_pkg::VSLOT_W-1:0]        ovoice_reg, ovoice_next;
    logic [sva_pkg::NOTE_W-1:0]         onote_reg, onote_next;
    logic [sva_pkg::VEL_W-1:0]          ovel_reg, ovel_next;
    logic [sva_pkg::SPATCH_W-1:0]       opatch_reg, opatch_next;
    logic                               oload_reg, oload_next;
    logic                               osec_reg, osec_next;
    logic                               olast_reg, olast_next;

    // combinational
    logic [5:0]                         vc_ext;
    logic [CW-1:0]                      n_eff;
    logic                               a_v, s_v;
    logic [sva_pkg::NOTE_W-1:0]         note_v;
    logic [sva_pkg::VCHAN_W-1:0]        ch_v;
    logic [sva_pkg::VTIME_W-1:0]        t_v;
    logic [sva_pkg::PATCH_W-1:0]        p_v;
    logic                               lt, onch, perc, vperc, role_ok;
    logic                               hit, upd, same_n, secf_n;
    logic                               out_free, idx_last, want_second, rest_any;
    logic [MAX_VOICES-1:0]              emit_m, above_m;
    logic [sva_pkg::PATCH_W-1:0]        new_patch;
    logic                               load_res;

    always_comb
    begin
        vc_ext = {1'b0, voice_count};
        if (vc_ext == 6'd0)
        begin
            n_eff = CW'(1);
        end
        else if (vc_ext > 6'(MAX_VOICES))
        begin
            n_eff = CW'(MAX_VOICES);
        end
        else
        begin
            n_eff = CW'(vc_ext);
        end
    end

    assign a_v     = act_reg[idx_reg];
    assign s_v     = vsec_reg[idx_reg];
    assign note_v  = vnote_reg[idx_reg];
    assign ch_v    = vch_reg[idx_reg];
    assign t_v     = vtime_reg[idx_reg];
    assign p_v     = vpatch_reg[idx_reg];

    assign lt      = $signed(t_v) < $signed(best_time_reg);
    assign onch    = (ch_v == {1'b0, ch_reg});
    assign perc    = (ch_reg == sva_pkg::PERC_CHAN);
    assign vperc   = perc && sva_pkg::perc_ok(note_reg);
    assign role_ok = onch && (s_v == scan_sec_reg);

    assign out_free    = !ovalid_reg || out_ready;
    assign idx_last    = ((CW'(idx_reg) + CW'(1)) == n_eff);
    // primary start drops free_count by one, so a secondary needs two free
    assign want_second = dbl_reg && dual_enable && (free_reg > CW'(1));

    // stop masks for the sweep: which voices in range give a result
    always_comb
    begin
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            above_m[i] = (VW'(i) > idx_reg);
            emit_m[i]  = 1'b0;
            if (CW'(i) < n_eff)
            begin
                if (req_reg == sva_pkg::REQ_NOTE_OFF)
                begin
                    emit_m[i] = (vnote_reg[i] == note_reg) && (vch_reg[i] == {1'b0, ch_reg});
                end
                else if (req_reg == sva_pkg::REQ_RESET)
                begin
                    emit_m[i] = act_reg[i];
                end
            end
        end
    end

    assign rest_any = |(emit_m & above_m);

    // one selection step, free or steal pick
    always_comb
    begin
        hit    = 1'b0;
        upd    = 1'b0;
        same_n = same_reg;
        secf_n = secf_reg;
        if (!steal_reg)
        begin
            if (!a_v)
            begin
                if (role_ok && (note_v == note_reg))
                begin
                    hit = 1'b1;
                end
                else if (role_ok && (!perc || (!vperc && !sva_pkg::perc_ok(note_v))))
                begin
                    if (!same_reg || lt)
                    begin
                        upd    = 1'b1;
                        same_n = 1'b1;
                    end
                end
                else if (!same_reg && (lt || ((t_v == best_time_reg) &&
                         (p_v != sva_pkg::PATCH_NONE) && (p_v >= sva_pkg::INSTR_LIMIT))))
                begin
                    upd = 1'b1;
                end
            end
        end
        else
        begin
            if (s_v)
            begin
                if (!secf_reg || (!same_reg && onch))
                begin
                    upd    = 1'b1;
                    secf_n = 1'b1;
                    same_n = onch;
                end
                else if (!(same_reg && !onch) && lt)
                begin
                    upd = 1'b1;
                end
            end
            else if (!secf_reg && !(same_reg && !onch))
            begin
                if (!same_reg && onch)
                begin
                    upd    = 1'b1;
                    same_n = 1'b1;
                end
                else if (lt)
                begin
                    upd = 1'b1;
                end
            end
        end
    end

    assign new_patch = scan_sec_reg ? {1'b0, spatch_reg} : {2'b00, ppatch_reg};
    assign load_res  = cmd.start_voice || (cmd.sweep_step && emit_m[idx_reg]);

    always_comb
    begin
        act_next        = act_reg;
        vsec_next       = vsec_reg;
        vnote_next      = vnote_reg;
        vch_next        = vch_reg;
        vtime_next      = vtime_reg;
        vpatch_next     = vpatch_reg;
        free_next       = free_reg;
        idx_next        = idx_reg;
        best_voice_next = best_voice_reg;
        best_time_next  = best_time_reg;
        best_patch_next = best_patch_reg;
        same_next       = same_reg;
        secf_next       = secf_reg;
        scan_sec_next   = scan_sec_reg;
        steal_next      = steal_reg;
        oact_next       = oact_reg;
        ovoice_next     = ovoice_reg;
        onote_next      = onote_reg;
        ovel_next       = ovel_reg;
        opatch_next     = opatch_reg;
        oload_next      = oload_reg;
        osec_next       = osec_reg;
        olast_next      = olast_reg;
        ovalid_next     = load_res ? 1'b1 : (out_ready ? 1'b0 : ovalid_reg);

        if (cmd.load_req)
        begin
            idx_next        = '0;
            best_voice_next = '0;
            best_time_next  = {1'b0, now};
            same_next       = 1'b0;
            secf_next       = 1'b0;
            scan_sec_next   = 1'b0;
            steal_next      = (free_reg == '0);
        end

        if (cmd.scan_step)
        begin
            idx_next  = idx_reg + VW'(1);
            same_next = same_n;
            secf_next = secf_n;
            if (hit || upd)
            begin
                best_voice_next = idx_reg;
                best_time_next  = t_v;
            end
            // voice 0 is the fallback pick, so its patch is always kept
            if (hit || upd || (idx_reg == '0))
            begin
                best_patch_next = p_v;
            end
        end

        if (cmd.start_voice)
        begin
            act_next[best_voice_reg]    = 1'b1;
            vsec_next[best_voice_reg]   = scan_sec_reg;
            vnote_next[best_voice_reg]  = note_reg;
            vch_next[best_voice_reg]    = {1'b0, ch_reg};
            vtime_next[best_voice_reg]  = {1'b0, now_reg};
            vpatch_next[best_voice_reg] = new_patch;
            if (free_reg != '0)
            begin
                free_next = free_reg - CW'(1);
            end
            oact_next   = sva_pkg::ACT_START;
            ovoice_next = sva_pkg::VSLOT_W'(best_voice_reg);
            onote_next  = note_reg;
            ovel_next   = vel_reg;
            opatch_next = new_patch[sva_pkg::SPATCH_W-1:0];
            oload_next  = (best_patch_reg != new_patch);
            osec_next   = scan_sec_reg;
            olast_next  = scan_sec_reg || !want_second;
        end

        if (cmd.init_second)
        begin
            idx_next        = '0;
            best_voice_next = '0;
            best_time_next  = {1'b0, now_reg};
            same_next       = 1'b0;
            secf_next       = 1'b0;
            scan_sec_next   = 1'b1;
            steal_next      = 1'b0;
        end

        if (cmd.sweep_step)
        begin
            idx_next = idx_reg + VW'(1);
            case (req_reg)
                sva_pkg::REQ_NOTE_OFF:
                begin
                    if (emit_m[idx_reg])
                    begin
                        if (a_v && (free_reg < n_eff))
                        begin
                            free_next = free_reg + CW'(1);
                        end
                        act_next[idx_reg]   = 1'b0;
                        vtime_next[idx_reg] = {1'b0, now_reg};
                    end
                end
                sva_pkg::REQ_RESET:
                begin
                    act_next[idx_reg]   = 1'b0;
                    vtime_next[idx_reg] = sva_pkg::TIME_NONE;
                    free_next           = n_eff;
                end
                sva_pkg::REQ_REBASE:
                begin
                    vtime_next[idx_reg] = t_v - {1'b0, now_reg};
                end
                default:
                begin
                end
            endcase
            if (emit_m[idx_reg])
            begin
                oact_next   = sva_pkg::ACT_STOP;
                ovoice_next = sva_pkg::VSLOT_W'(idx_reg);
                onote_next  = (req_reg == sva_pkg::REQ_RESET) ? note_v : note_reg;
                ovel_next   = (req_reg == sva_pkg::REQ_RESET) ? sva_pkg::RESET_VEL : vel_reg;
                opatch_next = (p_v == sva_pkg::PATCH_NONE) ? '0 : p_v[sva_pkg::SPATCH_W-1:0];
                oload_next  = 1'b0;
                osec_next   = s_v;
                olast_next  = !rest_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= '0;
            vsec_reg     <= '0;
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                vnote_reg[i]  <= '0;
                vch_reg[i]    <= sva_pkg::CHAN_NONE;
                vtime_reg[i]  <= sva_pkg::TIME_NONE;
                vpatch_reg[i] <= sva_pkg::PATCH_NONE;
            end
            free_reg     <= CW'(FREE_RST);
            idx_reg      <= '0;
            same_reg     <= 1'b0;
            secf_reg     <= 1'b0;
            scan_sec_reg <= 1'b0;
            steal_reg    <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            act_reg      <= act_next;
            vsec_reg     <= vsec_next;
            vnote_reg    <= vnote_next;
            vch_reg      <= vch_next;
            vtime_reg    <= vtime_next;
            vpatch_reg   <= vpatch_next;
            free_reg     <= free_next;
            idx_reg      <= idx_next;
            same_reg     <= same_next;
            secf_reg     <= secf_next;
            scan_sec_reg <= scan_sec_next;
            steal_reg    <= steal_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg    <= req_type;
            note_reg   <= note;
            ch_reg     <= channel;
            vel_reg    <= velocity;
            ppatch_reg <= primary_patch;
            spatch_reg <= secondary_patch;
            dbl_reg    <= double_voice;
            now_reg    <= now;
        end
        best_voice_reg <= best_voice_next;
        best_time_reg  <= best_time_next;
        best_patch_reg <= best_patch_next;
        oact_reg       <= oact_next;
        ovoice_reg     <= ovoice_next;
        onote_reg      <= onote_next;
        ovel_reg       <= ovel_next;
        opatch_reg     <= opatch_next;
        oload_reg      <= oload_next;
        osec_reg       <= osec_next;
        olast_reg      <= olast_next;
    end

    assign status.scan_end    = idx_last || hit;
    assign status.want_second = want_second;
    assign status.sweep_last  = idx_last;
    assign status.sweep_emit  = emit_m[idx_reg];
    assign status.out_free    = out_free;

    assign out_valid    = ovalid_reg;
    assign action       = oact_reg;
    assign voice        = ovoice_reg;
    assign note_out     = onote_reg;
    assign velocity_out = ovel_reg;
    assign patch        = opatch_reg;
    assign patch_load   = oload_reg;
    assign is_secondary = osec_reg;
    assign last         = olast_reg;

endmodule

// File: hdl/synth_voice_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// synth_voice_allocator
// Assigns note events to FM synth voices: free/steal selection, optional
// secondary voice, note-off, reset-all and timestamp rebase.
// ============================================================================
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ---------------------------------
//  input     in_valid / in_ready          req_type note channel velocity
//                                         primary_patch secondary_patch
//                                         double_voice now
//  output    out_valid / out_ready        action voice note_out velocity_out
//                                         patch patch_load is_secondary last
//  config    APB psel/penable/pwrite      voice_count @0x0, dual enable @0x4
//
//  One request at a time; N = active voice count. Selection scans one voice
//  per clock over the voice register file read port: note-on scans at most
//  N voices per voice started (early exit on an exact match), up to two
//  starts. Note-off, reset and rebase sweep all N voices. Stops stall the
//  sweep while the result register is full. Reset restores all voice state
//  in the same cycle; no clearing pass.
//
module synth_voice_allocator
#(
    parameter int MAX_VOICES = sva_pkg::MAX_VOICES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sva_pkg::REQ_W-1:0]        req_type,
    input  logic [sva_pkg::NOTE_W-1:0]       note,
    input  logic [sva_pkg::CHAN_W-1:0]       channel,
    input  logic [sva_pkg::VEL_W-1:0]        velocity,
    input  logic [sva_pkg::PPATCH_W-1:0]     primary_patch,
    input  logic [sva_pkg::SPATCH_W-1:0]     secondary_patch,
    input  logic                             double_voice,
    input  logic [sva_pkg::NOW_W-1:0]        now,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             action,
    output logic [sva_pkg::VSLOT_W-1:0]      voice,
    output logic [sva_pkg::NOTE_W-1:0]       note_out,
    output logic [sva_pkg::VEL_W-1:0]        velocity_out,
    output logic [sva_pkg::SPATCH_W-1:0]     patch,
    output logic                             patch_load,
    output logic                             is_secondary,
    output logic                             last,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sva_pkg::APB_AW-1:0]       paddr,
    input  logic [sva_pkg::APB_DW-1:0]       pwdata,
    output logic [sva_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    logic [sva_pkg::VCNT_W-1:0] vcount_reg, vcount_next;
    logic                       dual_reg, dual_next;
    logic                       wr_en;
    sva_pkg::sva_cmd_t          cmd;
    sva_pkg::sva_status_t       status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        vcount_next = vcount_reg;
        dual_next   = dual_reg;
        if (wr_en)
        begin
            case (paddr[2])
                sva_pkg::REG_VOICE_COUNT: vcount_next = pwdata[sva_pkg::VCNT_W-1:0];
                sva_pkg::REG_DUAL_ENABLE: dual_next   = pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sva_pkg::REG_VOICE_COUNT: prdata = {{(sva_pkg::APB_DW-sva_pkg::VCNT_W){1'b0}},
                                                vcount_reg};
            sva_pkg::REG_DUAL_ENABLE: prdata = {{(sva_pkg::APB_DW-1){1'b0}}, dual_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= sva_pkg::VCNT_W'(sva_pkg::VOICE_COUNT_RST);
            dual_reg   <= 1'b1;
        end
        else
        begin
            vcount_reg <= vcount_next;
            dual_reg   <= dual_next;
        end
    end

    sva_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    sva_dp
    #(
        .MAX_VOICES (MAX_VOICES)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .voice_count     (vcount_reg),
        .dual_enable     (dual_reg),
        .req_type        (req_type),
        .note            (note),
        .channel         (channel),
        .velocity        (velocity),
        .primary_patch   (primary_patch),
        .secondary_patch (secondary_patch),
        .double_voice    (double_voice),
        .now             (now),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .action          (action),
        .voice           (voice),
        .note_out        (note_out),
        .velocity_out    (velocity_out),
        .patch           (patch),
        .patch_load      (patch_load),
        .is_secondary    (is_secondary),
        .last            (last)
    );

endmodule
